FILE: sv/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
// Used by cau_div_cell and complex_arithmetic_unit; depends on nothing.
package cau_pkg;

  localparam int FRAC_BITS = 8;              // Q8.8 fraction bits
  localparam int OW        = 16;             // width of one result part
  localparam int QB        = 17;             // quotient bits built by the cell chain
  localparam int DW        = 32;             // divisor (squared magnitude) width
  localparam int MW        = DW + FRAC_BITS; // scaled numerator magnitude width

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  // One division lane: partial remainder plus numerator bits still to shift in.
  // The quotient collects at the bottom of low as numerator bits leave the top.
  typedef struct packed {
    logic          neg;
    logic          big;
    logic [DW-1:0] rem;
    logic [QB-1:0] low;
  } lane_t;

  // Item travelling down the cell chain.
  typedef struct packed {
    logic                 valid;
    logic                 div;
    logic [DW-1:0]        den;
    lane_t                re;
    lane_t                im;
    logic signed [OW-1:0] res_re;
    logic signed [OW-1:0] res_im;
    logic                 eq;
    logic                 ovf;
    logic                 dz;
  } pipe_t;

  // Saturate to 16 bits signed; top bit of the result is the overflow flag.
  function automatic logic [OW:0] sat16(input logic signed [47:0] x);
    logic [OW:0] r;
    if (x > 48'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (x < -48'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, x[OW-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: sv/cau_div_cell.sv
// One restoring-division cell: retires one quotient bit for both lanes.
// Depends on cau_pkg.
module cau_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  cau_pkg::pipe_t d_in,
  output cau_pkg::pipe_t d_out
);

  cau_pkg::pipe_t d_nxt;
  cau_pkg::pipe_t d_r;

  // shift one numerator bit into the remainder, subtract when it fits
  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l,
                                          input logic [cau_pkg::DW-1:0] den);
    cau_pkg::lane_t  o;
    logic [cau_pkg::DW:0] sh;
    logic             ge;
    sh = {l.rem, l.low[cau_pkg::QB-1]};
    ge = (sh >= {1'b0, den});
    o  = l;
    o.rem = ge ? cau_pkg::DW'(sh - {1'b0, den}) : sh[cau_pkg::DW-1:0];
    o.low = {l.low[cau_pkg::QB-2:0], ge};
    return o;
  endfunction

  always_comb begin
    d_nxt    = d_in;
    d_nxt.re = step(d_in.re, d_in.den);
    d_nxt.im = step(d_in.im, d_in.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
    d_r.div    <= d_nxt.div;
    d_r.den    <= d_nxt.den;
    d_r.re     <= d_nxt.re;
    d_r.im     <= d_nxt.im;
    d_r.res_re <= d_nxt.res_re;
    d_r.res_im <= d_nxt.res_im;
    d_r.eq     <= d_nxt.eq;
    d_r.ovf    <= d_nxt.ovf;
    d_r.dz     <= d_nxt.dz;
  end

  assign d_out = d_r;

endmodule

FILE: sv/complex_arithmetic_unit.sv
// Complex add, subtract, multiply, divide and compare on Q8.8 operands.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The divide runs through a chain of 17 cells, one quotient bit each.
// Synchronous active-low reset clears all valid bits; no results are lost
// since the receiver cannot stall. Depends on cau_pkg and cau_div_cell.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [15:0] in_a_re,
  input  logic signed [15:0] in_a_im,
  input  logic signed [15:0] in_b_re,
  input  logic signed [15:0] in_b_im,
  output logic               out_valid,
  output logic signed [15:0] out_res_re,
  output logic signed [15:0] out_res_im,
  output logic               out_equal,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  // stage 1: operand registers
  logic               s1_valid_r;
  logic [2:0]         s1_op_r;
  logic signed [15:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  // stage 2: products, add/sub and compare results
  logic               s2_valid_r;
  logic [2:0]         s2_op_r;
  logic signed [31:0] s2_rr_r, s2_ii_r, s2_ri_r, s2_ir_r, s2_bb_r, s2_cc_r;
  logic signed [15:0] s2_re_r, s2_im_r;
  logic               s2_ovf_r, s2_eq_r;
  logic [16:0]        s2_sre, s2_sim;

  // stage 3: sums of products
  logic               s3_valid_r;
  logic [2:0]         s3_op_r;
  logic signed [32:0] s3_mre_r, s3_mim_r, s3_dre_r, s3_dim_r;
  logic [31:0]        s3_den_r;
  logic signed [15:0] s3_re_r, s3_im_r;
  logic               s3_ovf_r, s3_eq_r;

  // stage 4: chain entry
  cau_pkg::pipe_t     s4_nxt, s4_r;
  cau_pkg::pipe_t     chain [cau_pkg::QB+1];

  // output stage
  logic               fin_valid_nxt;
  logic signed [15:0] fin_re_nxt, fin_im_nxt;
  logic               fin_eq_nxt, fin_ovf_nxt, fin_dz_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_re_r, out_im_r;
  logic               out_eq_r, out_ovf_r, out_dz_r;

  assign busy = 1'b0;

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_op_r <= in_operation;
    s1_ar_r <= in_a_re;
    s1_ai_r <= in_a_im;
    s1_br_r <= in_b_re;
    s1_bi_r <= in_b_im;
  end

  // stage 2: multipliers and the short operations
  always_comb begin
    if (s1_op_r == cau_pkg::OP_SUB) begin
      s2_sre = cau_pkg::sat16(48'(17'(s1_ar_r) - 17'(s1_br_r)));
      s2_sim = cau_pkg::sat16(48'(17'(s1_ai_r) - 17'(s1_bi_r)));
    end else begin
      s2_sre = cau_pkg::sat16(48'(17'(s1_ar_r) + 17'(s1_br_r)));
      s2_sim = cau_pkg::sat16(48'(17'(s1_ai_r) + 17'(s1_bi_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_op_r <= s1_op_r;
    s2_rr_r <= s1_ar_r * s1_br_r;
    s2_ii_r <= s1_ai_r * s1_bi_r;
    s2_ri_r <= s1_ar_r * s1_bi_r;
    s2_ir_r <= s1_ai_r * s1_br_r;
    s2_bb_r <= s1_br_r * s1_br_r;
    s2_cc_r <= s1_bi_r * s1_bi_r;
    if (s1_op_r == cau_pkg::OP_ADD || s1_op_r == cau_pkg::OP_SUB) begin
      s2_re_r  <= s2_sre[15:0];
      s2_im_r  <= s2_sim[15:0];
      s2_ovf_r <= s2_sre[16] | s2_sim[16];
    end else begin
      s2_re_r  <= '0;
      s2_im_r  <= '0;
      s2_ovf_r <= 1'b0;
    end
    s2_eq_r <= (s1_op_r == cau_pkg::OP_CMP) && (s1_ar_r == s1_br_r) && (s1_ai_r == s1_bi_r);
  end

  // stage 3: sums of products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_op_r  <= s2_op_r;
    s3_mre_r <= 33'(s2_rr_r) - 33'(s2_ii_r);
    s3_mim_r <= 33'(s2_ri_r) + 33'(s2_ir_r);
    s3_dre_r <= 33'(s2_rr_r) + 33'(s2_ii_r);
    s3_dim_r <= 33'(s2_ir_r) - 33'(s2_ri_r);
    s3_den_r <= 32'(s2_bb_r) + 32'(s2_cc_r);
    s3_re_r  <= s2_re_r;
    s3_im_r  <= s2_im_r;
    s3_ovf_r <= s2_ovf_r;
    s3_eq_r  <= s2_eq_r;
  end

  // set up a division lane: magnitude, scaling, leading remainder
  function automatic cau_pkg::lane_t lane_init(input logic signed [32:0] d,
                                               input logic [31:0] den);
    cau_pkg::lane_t          l;
    logic [31:0]             mag;
    logic [cau_pkg::MW-1:0]  mn;
    logic [cau_pkg::DW-1:0]  r0;
    mag   = d[32] ? 32'(-d) : 32'(d);
    mn    = {mag, {cau_pkg::FRAC_BITS{1'b0}}};
    r0    = cau_pkg::DW'(mn >> cau_pkg::QB);
    l.neg = d[32];
    l.big = (r0 >= den);
    l.rem = l.big ? '0 : r0;
    l.low = mn[cau_pkg::QB-1:0];
    return l;
  endfunction

  // stage 4: multiply saturation, divide setup
  always_comb begin
    logic [16:0] mre, mim;
    mre = cau_pkg::sat16(48'(s3_mre_r >>> cau_pkg::FRAC_BITS));
    mim = cau_pkg::sat16(48'(s3_mim_r >>> cau_pkg::FRAC_BITS));
    s4_nxt.valid  = s3_valid_r;
    s4_nxt.div    = (s3_op_r == cau_pkg::OP_DIV) && (s3_den_r != '0);
    s4_nxt.den    = s3_den_r;
    s4_nxt.re     = lane_init(s3_dre_r, s3_den_r);
    s4_nxt.im     = lane_init(s3_dim_r, s3_den_r);
    s4_nxt.res_re = s3_re_r;
    s4_nxt.res_im = s3_im_r;
    s4_nxt.ovf    = s3_ovf_r;
    s4_nxt.eq     = s3_eq_r;
    s4_nxt.dz     = (s3_op_r == cau_pkg::OP_DIV) && (s3_den_r == '0);
    if (s3_op_r == cau_pkg::OP_MUL) begin
      s4_nxt.res_re = mre[15:0];
      s4_nxt.res_im = mim[15:0];
      s4_nxt.ovf    = mre[16] | mim[16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r.valid <= s4_nxt.valid;
    end
    s4_r.div    <= s4_nxt.div;
    s4_r.den    <= s4_nxt.den;
    s4_r.re     <= s4_nxt.re;
    s4_r.im     <= s4_nxt.im;
    s4_r.res_re <= s4_nxt.res_re;
    s4_r.res_im <= s4_nxt.res_im;
    s4_r.eq     <= s4_nxt.eq;
    s4_r.ovf    <= s4_nxt.ovf;
    s4_r.dz     <= s4_nxt.dz;
  end

  // division cell chain, one quotient bit per cell
  assign chain[0] = s4_r;
  for (genvar k = 0; k < cau_pkg::QB; k++) begin : g_cell
    cau_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  // signed quotient, saturated
  function automatic logic [16:0] lane_fin(input cau_pkg::lane_t l);
    logic signed [18:0] q;
    logic [16:0]        r;
    q = l.neg ? -19'(l.low) : 19'(l.low);
    if (l.big) begin
      r = l.neg ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
    end else begin
      r = cau_pkg::sat16(48'(q));
    end
    return r;
  endfunction

  // output stage
  always_comb begin
    logic [16:0] qre, qim;
    qre           = lane_fin(chain[cau_pkg::QB].re);
    qim           = lane_fin(chain[cau_pkg::QB].im);
    fin_valid_nxt = chain[cau_pkg::QB].valid;
    fin_re_nxt    = chain[cau_pkg::QB].res_re;
    fin_im_nxt    = chain[cau_pkg::QB].res_im;
    fin_ovf_nxt   = chain[cau_pkg::QB].ovf;
    fin_eq_nxt    = chain[cau_pkg::QB].eq;
    fin_dz_nxt    = chain[cau_pkg::QB].dz;
    if (chain[cau_pkg::QB].div) begin
      fin_re_nxt  = qre[15:0];
      fin_im_nxt  = qim[15:0];
      fin_ovf_nxt = qre[16] | qim[16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_valid_nxt;
    end
    out_re_r  <= fin_re_nxt;
    out_im_r  <= fin_im_nxt;
    out_eq_r  <= fin_eq_nxt;
    out_ovf_r <= fin_ovf_nxt;
    out_dz_r  <= fin_dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_res_re         = out_re_r;
  assign out_res_im         = out_im_r;
  assign out_equal          = out_eq_r;
  assign out_overflow       = out_ovf_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

FILE: bench/tb.sv
// Self-checking bench for complex_arithmetic_unit: directed and random complex
// operand items, predicted in-bench and compared against every out_valid strobe.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] a_re, a_im, b_re, b_im;
  } operand_t;

  typedef struct {
    logic signed [15:0] re, im;
    logic               eq, ovf, dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic signed [15:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic signed [15:0] out_res_re, out_res_im;
  logic out_equal, out_overflow, out_divide_by_zero;

  operand_t  pending_items[$];
  cplx_res_t expected_results[$];
  int        mismatch_count = 0;
  int        checked_count = 0;
  int        sent_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  bit        hold_send = 1'b0;

  complex_arithmetic_unit uut (.*);

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a wide value to 16 bits, noting overflow
  function automatic logic signed [15:0] clamp16(input longint x, inout logic ovf);
    if (x > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (x < -32768) begin
      ovf = 1'b1;
      return -16'sh8000;
    end
    return 16'(x);
  endfunction

  // Expected result of one operand item
  function automatic cplx_res_t predict_complex(input operand_t it);
    cplx_res_t r;
    longint ar, ai, br, bi, den, nre, nim;
    logic ovf;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    ovf = 1'b0;
    r = '{re: 0, im: 0, eq: 1'b0, ovf: 1'b0, dz: 1'b0};
    case (it.op)
      cau_pkg::OP_ADD: begin
        r.re = clamp16(ar + br, ovf);
        r.im = clamp16(ai + bi, ovf);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp16(ar - br, ovf);
        r.im = clamp16(ai - bi, ovf);
      end
      cau_pkg::OP_MUL: begin
        // arithmetic shift floors toward negative infinity
        r.re = clamp16((ar * br - ai * bi) >>> cau_pkg::FRAC_BITS, ovf);
        r.im = clamp16((ar * bi + ai * br) >>> cau_pkg::FRAC_BITS, ovf);
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          // SV integer divide truncates toward zero
          nre = (ar * br + ai * bi) * (64'sd1 <<< cau_pkg::FRAC_BITS);
          nim = (ai * br - ar * bi) * (64'sd1 <<< cau_pkg::FRAC_BITS);
          r.re = clamp16(nre / den, ovf);
          r.im = clamp16(nim / den, ovf);
        end
      end
      cau_pkg::OP_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Driver: one item per cycle unless idling or held off
  always @(posedge clk) begin
    if (rst_n && start && !busy) sent_count <= sent_count + 1;
    if (rst_n && (!start || !busy)) begin
      if (pending_items.size() > 0 && !hold_send &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        operand_t it;
        it = pending_items.pop_front();
        expected_results.push_back(predict_complex(it));
        start <= 1'b1;
        in_operation <= it.op;
        in_a_re <= it.a_re;
        in_a_im <= it.a_im;
        in_b_re <= it.b_re;
        in_b_im <= it.b_im;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_valid, 0);
      end else begin
        cplx_res_t w;
        w = expected_results.pop_front();
        checked_count++;
        if (out_res_re !== w.re) report_mismatch("res_re", out_res_re, w.re);
        if (out_res_im !== w.im) report_mismatch("res_im", out_res_im, w.im);
        if (out_equal !== w.eq) report_mismatch("equal", out_equal, w.eq);
        if (out_overflow !== w.ovf) report_mismatch("overflow", out_overflow, w.ovf);
        if (out_divide_by_zero !== w.dz)
          report_mismatch("divide_by_zero", out_divide_by_zero, w.dz);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_part();
    case ($urandom_range(5, 0))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(1024, 0)) - 16'sd512;
      3: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic operand_t rand_item();
    operand_t it;
    it.op = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    it.a_re = rand_part();
    it.a_im = rand_part();
    it.b_re = rand_part();
    it.b_im = rand_part();
    if (it.op == cau_pkg::OP_CMP && $urandom_range(1, 0)) begin
      it.b_re = it.a_re;
      if ($urandom_range(3, 0) != 0) it.b_im = it.a_im;
    end
    if (it.op == cau_pkg::OP_DIV && $urandom_range(9, 0) == 0) begin
      it.b_re = 0;
      it.b_im = 0;
    end
    return it;
  endfunction

  task automatic add_item(input logic [2:0] op, input int ar, ai, br, bi);
    pending_items.push_back('{op, 16'(ar), 16'(ai), 16'(br), 16'(bi)});
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each operation, zero divisor, compare, unused codes
    add_item(cau_pkg::OP_ADD, 32767, -32768, 1, -1);
    add_item(cau_pkg::OP_ADD, -32768, 32767, -32768, 32767);
    add_item(cau_pkg::OP_SUB, -32768, 32767, 1, -1);
    add_item(cau_pkg::OP_SUB, 32767, -32768, 32767, -32768);
    add_item(cau_pkg::OP_MUL, 256, 256, 256, -256);
    add_item(cau_pkg::OP_MUL, -32768, -32768, -32768, 32767);
    add_item(cau_pkg::OP_MUL, -1, 0, 1, 0);
    add_item(cau_pkg::OP_MUL, 32767, 32767, 32767, 32767);
    add_item(cau_pkg::OP_DIV, 256, 0, 0, 0);
    add_item(cau_pkg::OP_DIV, 512, 256, 256, 0);
    add_item(cau_pkg::OP_DIV, 32767, -32768, 1, 0);
    add_item(cau_pkg::OP_DIV, -1, 1, 3, 7);
    add_item(cau_pkg::OP_DIV, -32768, -32768, -32768, -32768);
    add_item(cau_pkg::OP_CMP, 5, -5, 5, -5);
    add_item(cau_pkg::OP_CMP, 5, -5, 5, -4);
    add_item(cau_pkg::OP_CMP, -32768, 32767, -32768, 32767);
    add_item(3'd5, 1, 2, 3, 4);
    add_item(3'd6, -1, -1, -1, -1);
    add_item(3'd7, 32767, 32767, 32767, 32767);
    drain();

    // Hold the sender while ten random items queue up, then release them and drain
    hold_send = 1'b1;
    for (int i = 0; i < 10; i++) pending_items.push_back(rand_item());
    repeat (5) @(posedge clk);
    hold_send = 1'b0;
    drain();

    // Random phases: sender idles 18%, then 65%, then not at all
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 18 : (p == 1) ? 65 : 0;
      for (int i = 0; i < 410; i++) pending_items.push_back(rand_item());
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d items, checked %0d results across all five operations,",
             sent_count, checked_count);
    $display("unused codes, zero divisors and saturation, under three idle mixes.");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: complex_arithmetic_unit.f
sv/cau_pkg.sv
sv/cau_div_cell.sv
sv/complex_arithmetic_unit.sv
bench/tb.sv
